>>> design/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

>>> design/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: r = a * b mod m, one bit of b per cycle.
module mexp_mulmod (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mexp_pkg::word_t a_i,
  input  mexp_pkg::word_t b_i,
  input  mexp_pkg::word_t m_i,
  output logic          done_o,
  output mexp_pkg::word_t r_o
);
  import mexp_pkg::*;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  cnt_t          cnt_q, cnt_d;
  word_t         a_q, a_d;
  word_t         b_q, b_d;
  word_t         m_q, m_d;
  word_t         r_q, r_d;
  logic [WIDTH+1:0] s0, s1, s2, m1x, m2x;

  assign m1x = {2'b00, m_q};
  assign m2x = {1'b0, m_q, 1'b0};

  // 2r + bit*a stays below 3m, so at most two subtractions of m are needed
  always_comb begin
    s0 = {1'b0, r_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : {(WIDTH+2){1'b0}});
    s1 = s0 - m1x;
    s2 = s0 - m2x;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = cnt_t'(WIDTH - 1);
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (s0 >= m2x) begin
        r_d = s2[WIDTH-1:0];
      end else if (s0 >= m1x) begin
        r_d = s1[WIDTH-1:0];
      end else begin
        r_d = s0[WIDTH-1:0];
      end
      b_d = {b_q[WIDTH-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    m_q <= m_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

>>> design/modular_exponentiation_top.sv
// Top level: left-to-right binary modular exponentiation sequencer.
// An item (base, exponent, modulus) is taken when start is high and busy is low.
// The base is first reduced modulo the modulus, then all WIDTH exponent bits are
// scanned from the top: a modular square for every bit and a modular multiply by
// the reduced base for every one bit. Each of these passes goes through one shared
// bit-serial multiplier, one pass after another, so an item whose exponent has more
// one bits takes longer. A modulus of zero answers 0 in the cycle after it is taken.
// The result appears for exactly one cycle with result_valid_o high; the receiver
// cannot stall it, so it must take it in that cycle. A new item may be started while
// a result is shown.
module modular_exponentiation_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mexp_pkg::word_t base_value_i,
  input  mexp_pkg::word_t exponent_value_i,
  input  mexp_pkg::word_t modulus_value_i,
  output logic            result_valid_o,
  output mexp_pkg::word_t power_result_o
);
  import mexp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_SQ   = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       valid_q, valid_d;
  cnt_t       bit_q, bit_d;
  word_t      exp_q, exp_d;
  word_t      m_q, m_d;
  word_t      base_q, base_d;
  word_t      result_q, result_d;
  word_t      acc_init;
  logic       accept;

  logic       mm_start;
  word_t      mm_a, mm_b, mm_m;
  logic       mm_done;
  word_t      mm_r;

  mexp_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (mm_m),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  assign accept   = start && (state_q == S_IDLE);
  assign acc_init = (m_q == word_t'(1)) ? '0 : word_t'(1);

  always_comb begin
    state_d  = state_q;
    valid_d  = 1'b0;
    bit_d    = bit_q;
    exp_d    = exp_q;
    m_d      = m_q;
    base_d   = base_q;
    result_d = result_q;
    mm_start = 1'b0;
    mm_a     = mm_r;
    mm_b     = mm_r;
    mm_m     = m_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          exp_d = exponent_value_i;
          m_d   = modulus_value_i;
          bit_d = cnt_t'(WIDTH - 1);
          if (modulus_value_i == '0) begin
            valid_d  = 1'b1;
            result_d = '0;
          end else begin
            // base mod m through the multiplier: 1 * base mod m
            mm_start = 1'b1;
            mm_a     = word_t'(1);
            mm_b     = base_value_i;
            mm_m     = modulus_value_i;
            state_d  = S_RED;
          end
        end
      end
      S_RED: begin
        if (mm_done) begin
          base_d   = mm_r;
          mm_start = 1'b1;
          mm_a     = acc_init;
          mm_b     = acc_init;
          state_d  = S_SQ;
        end
      end
      S_SQ, S_MUL: begin
        if (mm_done) begin
          if (state_q == S_SQ && exp_q[WIDTH-1]) begin
            mm_start = 1'b1;
            mm_a     = mm_r;
            mm_b     = base_q;
            state_d  = S_MUL;
          end else if (bit_q == '0) begin
            valid_d  = 1'b1;
            result_d = mm_r;
            state_d  = S_IDLE;
          end else begin
            bit_d    = bit_q - cnt_t'(1);
            exp_d    = {exp_q[WIDTH-2:0], 1'b0};
            mm_start = 1'b1;
            state_d  = S_SQ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q    <= exp_d;
    m_q      <= m_d;
    base_q   <= base_d;
    result_q <= result_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign power_result_o = result_q;

  a_result_below_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (m_q != '0) |-> power_result_o < m_q)
    else $error("result not reduced below modulus");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy || result_valid_o)
    else $error("accepted item neither in work nor answered");

  a_done_when_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> state_q != S_IDLE)
    else $error("multiplier finished while sequencer idle");

  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(state_q) != S_IDLE |-> !busy)
    else $error("result shown while still working");

endmodule

>>> tb/tb_top.sv
// Self-checking bench for modular_exponentiation_top: queued stimulus, clocked driver/monitor.
module tb_top;
  import mexp_pkg::*;

  localparam int unsigned DIRECTED_N  = 20;
  localparam int unsigned RANDOM_N    = 260;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct {
    word_t       base;
    word_t       expo;
    word_t       modulus;
    int unsigned gap;
  } operand_t;

  logic  clk   = 1'b0;
  logic  rst_n = 1'b0;
  logic  start_q = 1'b0;
  word_t base_q    = '0;
  word_t expo_q    = '0;
  word_t modulus_q = '0;
  logic  busy;
  logic  result_valid;
  word_t power_result;

  operand_t    operand_queue[$];
  word_t       power_expected[$];
  int unsigned mismatch_count = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned cycle_count    = 0;
  int unsigned gap_count      = 0;

  modular_exponentiation_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start_q),
    .busy            (busy),
    .base_value_i    (base_q),
    .exponent_value_i(expo_q),
    .modulus_value_i (modulus_q),
    .result_valid_o  (result_valid),
    .power_result_o  (power_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Square-and-multiply over all WIDTH exponent bits with exact 64-bit products.
  function automatic word_t mod_power(word_t b, word_t e, word_t m);
    logic [63:0] acc;
    logic [63:0] bred;
    logic [63:0] mm;
    int i;
    if (m == '0) return '0;
    mm   = {32'd0, m};
    bred = {32'd0, b} % mm;
    acc  = 64'd1 % mm;
    for (i = WIDTH - 1; i >= 0; i--) begin
      acc = (acc * acc) % mm;
      if (e[i]) acc = (acc * bred) % mm;
    end
    return acc[WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic add_item(input word_t b, input word_t e, input word_t m, input int unsigned g);
    operand_t it;
    it.base    = b;
    it.expo    = e;
    it.modulus = m;
    it.gap     = g;
    operand_queue.push_back(it);
  endtask

  function automatic word_t pick_modulus();
    case ($urandom_range(0, 7))
      0: return word_t'($urandom) | 32'h8000_0000;
      1: return word_t'($urandom_range(1, 255));
      2: return 32'd1;
      3: return 32'd1 << $urandom_range(0, 31);
      4: return word_t'($urandom_range(1, 65535));
      5: return 32'hFFFF_FFFF - $urandom_range(0, 100);
      default: return word_t'($urandom) | 32'd1;
    endcase
  endfunction

  function automatic word_t pick_base(word_t m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return m - 32'd1;
      3: return m;
      4: return 32'hFFFF_FFFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return word_t'($urandom_range(1, 15));
      2: return 32'hFFFF_FFFF;
      3: return 32'd1 << $urandom_range(0, 31);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Driver: each item waits its drawn gap, then start is held until accepted.
  always @(posedge clk or negedge rst_n) begin : driver
    logic        fire;
    logic        next_start;
    int unsigned next_wait;
    operand_t    it;
    if (!rst_n) begin
      start_q   <= 1'b0;
      gap_count <= 0;
    end else begin
      fire       = start_q && !busy;
      next_start = start_q;
      next_wait  = gap_count;
      if (fire) begin
        power_expected.push_back(mod_power(base_q, expo_q, modulus_q));
        accepted_count++;
        next_start = 1'b0;
      end
      if (!next_start && operand_queue.size() != 0) begin
        if (next_wait < operand_queue[0].gap) begin
          next_wait++;
        end else begin
          it         = operand_queue.pop_front();
          base_q    <= it.base;
          expo_q    <= it.expo;
          modulus_q <= it.modulus;
          next_start = 1'b1;
          next_wait  = 0;
        end
      end
      start_q   <= next_start;
      gap_count <= next_wait;
    end
  end

  // Monitor: results are shown for one cycle only, so sample every edge.
  always @(posedge clk) begin : monitor
    word_t want;
    if (rst_n && result_valid) begin
      if (power_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", power_result));
      end else begin
        want = power_expected.pop_front();
        checked_count++;
        if (power_result !== want)
          report_mismatch($sformatf("power_result %h, expected %h", power_result, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    word_t m;
    int unsigned k;
    // directed corners
    add_item(32'd0,         32'd0,         32'd1,         0);
    add_item(32'd5,         32'd0,         32'd7,         1);
    add_item(32'd0,         32'd5,         32'd13,        0);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,         2);
    add_item(32'd12345,     32'd0,         32'hFFFF_FFFF, 0);
    add_item(32'd7,         32'd3,         32'd0,         0);   // zero modulus
    add_item(32'd0,         32'd0,         32'd0,         5);
    add_item(32'd2,         32'hFFFF_FFFA, 32'hFFFF_FFFB, 0);   // Fermat: 2^(p-1) mod p
    add_item(32'd1,         32'hDEAD_BEEF, 32'hFFFF_FFFB, 0);
    add_item(32'hABCD_1234, 32'd1,         32'h0000_FFF1, 3);
    add_item(32'hFFFF_FFFB, 32'd9,         32'hFFFF_FFFB, 0);   // base equals modulus
    add_item(32'hFFFF_FFFF, 32'd2,         32'd10,        0);   // base above modulus
    add_item(32'd3,         32'h8000_0000, 32'h8000_0000, 1);
    add_item(32'd3,         32'hFFFF_FFFF, 32'd2,         0);
    add_item(32'hFFFF_FFFE, 32'd2,         32'hFFFF_FFFF, 4);
    add_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 0);
    add_item(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001, 0);
    add_item(32'd4,         32'd13,        32'd497,       2);
    add_item(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 0);
    for (int unsigned n = 0; n < RANDOM_N; n++) begin
      m = pick_modulus();
      // every third block of 40 runs back to back
      k = ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
      add_item(pick_base(m), pick_exponent(), m, k);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (operand_queue.size() != 0 || start_q || power_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d items (%0d directed corners, %0d random), %0d results checked",
             accepted_count, DIRECTED_N, RANDOM_N, checked_count);
    $display("Corners: zero/one/max moduli and exponents, base >= modulus, random stalls");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> modular_exponentiation_top.f
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation_top.sv
tb/tb_top.sv
